// ===== rtl/glyph_outline_dilate_3x3_assert.svh =====
// Assertion macros shared by the glyph outline dilation RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef GLYPH_OUTLINE_DILATE_3X3_ASSERT_SVH
`define GLYPH_OUTLINE_DILATE_3X3_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define GDIL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define GDIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gdil_pkg.sv =====
// Package for the glyph outline dilation block: field widths, register codes,
// result bundle type and the texel arithmetic. No dependencies.
`default_nettype none

package gdil_pkg;

    localparam int CELL_W        = 5;
    localparam int LINE_W        = 2 * CELL_W;
    localparam int WIN_W         = 3 * CELL_W;
    localparam int COV_W         = 8;
    localparam int TEXEL_W       = 16;
    localparam int ROW_W         = 11;
    localparam int OUT_COL_W     = 11;
    localparam int OFFS_W        = 27;
    localparam int PITCH_W       = 16;
    localparam int FRAME_FIELD_W = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int NUM_RES       = 4;
    localparam int MAX_HEIGHT    = 2048;

    localparam int FRAME_W_RST = 128;
    localparam int FRAME_H_RST = 128;
    localparam logic [PITCH_W-1:0] PITCH_RST = 16'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_PITCH   = 2'd2;

    // Result slots in emission order.
    localparam logic [1:0] RES_UP_MID  = 2'd0;
    localparam logic [1:0] RES_UP_END  = 2'd1;
    localparam logic [1:0] RES_LOW_MID = 2'd2;
    localparam logic [1:0] RES_LOW_END = 2'd3;

    // Window column layout: [14:10] two rows up, [9:5] one row up, [4:0] current row.
    localparam logic [WIN_W-1:0] FLAG_MASK    = 15'h4210;
    localparam logic [WIN_W-1:0] ROW_TOP_MASK = 15'h7C00;
    localparam logic [WIN_W-1:0] ROW_MID_MASK = 15'h03E0;
    localparam logic [WIN_W-1:0] ROW_CUR_MASK = 15'h001F;

    localparam logic [3:0] ALPHA_ON   = 4'hF;
    localparam logic [8:0] GREY_RECIP = 9'd241;
    localparam int         GREY_SHIFT = 12;

    typedef struct packed {
        logic [NUM_RES-1:0]              pend;
        logic [NUM_RES-1:0][TEXEL_W-1:0] texel;
    } bundle_t;

    // Cell = {nonzero flag, v/17}; v*241 >> 12 equals floor(v/17) for all 8-bit v.
    function automatic logic [CELL_W-1:0] cell_of(input logic [COV_W-1:0] v);
        logic [16:0] prod;
        prod = 17'(v) * 17'(GREY_RECIP);
        return {(v != '0), prod[GREY_SHIFT+3:GREY_SHIFT]};
    endfunction

    function automatic logic [TEXEL_W-1:0] make_texel(
        input logic [WIN_W-1:0] left,
        input logic             left_ok,
        input logic [WIN_W-1:0] center,
        input logic [WIN_W-1:0] right,
        input logic             right_ok,
        input logic [WIN_W-1:0] row_mask,
        input logic             upper
    );
        logic [WIN_W-1:0] hits;
        logic [3:0]       grey;
        logic [3:0]       alpha;
        hits  = center | (left_ok ? left : '0) | (right_ok ? right : '0);
        grey  = upper ? center[CELL_W+3:CELL_W] : center[3:0];
        alpha = ((hits & row_mask & FLAG_MASK) != '0) ? ALPHA_ON : 4'h0;
        return {alpha, grey, grey, grey};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gdil_if.sv =====
// Valid/ready channel interfaces for pixel input, texel output and register writes.
// Depends on gdil_pkg for the payload widths.
`default_nettype none

interface gdil_in_if import gdil_pkg::*;;
    logic             valid;
    logic             ready;
    logic [COV_W-1:0] coverage;

    modport source (output valid, output coverage, input ready);
    modport sink (input valid, input coverage, output ready);
endinterface

interface gdil_out_if import gdil_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [TEXEL_W-1:0]   texel;
    logic [OUT_COL_W-1:0] out_col;
    logic [ROW_W-1:0]     out_row;
    logic [OFFS_W-1:0]    dest_offset;
    logic                 frame_done;

    modport source (output valid, output texel, output out_col, output out_row,
                    output dest_offset, output frame_done, input ready);
    modport sink (input valid, input texel, input out_col, input out_row,
                  input dest_offset, input frame_done, output ready);
endinterface

interface gdil_cfg_if import gdil_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/gdil_linebuf.sv =====
// Line buffer memory: one entry per column holding the two previous rows' cells.
// One write and one registered read per cycle. Depends on gdil_pkg.
`default_nettype none

module gdil_linebuf import gdil_pkg::*;
#(
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [LINE_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [LINE_W-1:0] wr_data
);

    logic [LINE_W-1:0] mem [DEPTH];
    logic [LINE_W-1:0] rd_data_reg;

    // A read of the entry being written returns the old contents;
    // the window stage forwards in that case.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/gdil_window.sv =====
// Raster position tracking, configuration registers and the 3x3 window stage.
// Reads and writes the line buffer; depends on gdil_pkg, gdil_if and the assert macros.
`default_nettype none
`include "glyph_outline_dilate_3x3_assert.svh"

module gdil_window import gdil_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = $clog2(MAX_WIDTH)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    gdil_in_if.sink                pix,
    gdil_cfg_if.sink               cfg,
    output logic                   rd_en,
    output logic      [CW-1:0]     rd_addr,
    input  wire logic [LINE_W-1:0] rd_data,
    output logic                   wr_en,
    output logic      [CW-1:0]     wr_addr,
    output logic      [LINE_W-1:0] wr_data,
    output bundle_t                bndl,
    output logic                   bndl_valid,
    input  wire logic              bndl_ready,
    output logic      [CW-1:0]     bndl_col,
    output logic      [ROW_W-1:0]  bndl_row,
    output logic      [PITCH_W-1:0] pitch
);

    localparam int RST_LAST_COL = ((FRAME_W_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_W_RST) - 1;

    logic [CW-1:0]      last_col_reg, last_col_next;
    logic [ROW_W-1:0]   last_row_reg, last_row_next;
    logic [PITCH_W-1:0] pitch_reg, pitch_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               s1_valid_reg, s1_valid_next;
    logic               fwd_hit_reg, fwd_hit_next;
    logic [LINE_W-1:0]  fwd_data_reg;
    logic [CW-1:0]      s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic               s1_row_end_reg;
    logic               s1_last_row_reg;
    logic [CELL_W-1:0]  s1_cur_reg;
    logic [WIN_W-1:0]   win0_reg, win1_reg, win2_reg;

    logic               accept;
    logic               cfg_we;
    logic               s1_adv;
    logic [CW-1:0]      c_eff;
    logic [ROW_W-1:0]   r_eff;
    logic               row_end;
    logic               last_row;
    logic [31:0]        wv;
    logic [31:0]        hv;
    logic [LINE_W-1:0]  line;
    logic [WIN_W-1:0]   win_new;
    logic [WIN_W-1:0]   up_mask;
    logic [WIN_W-1:0]   low_mask;
    logic               c_ge1;
    logic               c_ge2;
    logic               r_ge1;

    assign accept = pix.valid && pix.ready;
    assign cfg_we = cfg.valid && cfg.ready;
    assign s1_adv = s1_valid_reg && bndl_ready;

    assign cfg.ready = 1'b1;
    assign pix.ready = !s1_valid_reg || s1_adv;

    // Counters left beyond a shrunken frame count as row end or last row.
    assign c_eff    = (col_reg > last_col_reg) ? last_col_reg : col_reg;
    assign r_eff    = (row_reg > last_row_reg) ? last_row_reg : row_reg;
    assign row_end  = (c_eff == last_col_reg);
    assign last_row = (r_eff == last_row_reg);

    // Register writes: widths and heights are stored as clamped last indexes.
    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        pitch_next    = pitch_reg;
        wv = 32'(cfg.data[FRAME_FIELD_W-1:0]);
        hv = 32'(cfg.data[FRAME_FIELD_W-1:0]);
        if (cfg_we)
        begin
            case (cfg.index)
                CFG_FRAME_WIDTH:
                begin
                    if (wv == 32'd0)
                        last_col_next = '0;
                    else if (wv > 32'(MAX_WIDTH))
                        last_col_next = CW'(MAX_WIDTH - 1);
                    else
                        last_col_next = CW'(wv - 32'd1);
                end
                CFG_FRAME_HEIGHT:
                begin
                    if (hv == 32'd0)
                        last_row_next = '0;
                    else if (hv > 32'(MAX_HEIGHT))
                        last_row_next = ROW_W'(MAX_HEIGHT - 1);
                    else
                        last_row_next = ROW_W'(hv - 32'd1);
                end
                CFG_DEST_PITCH:
                begin
                    pitch_next = cfg.data[PITCH_W-1:0];
                end
                default:
                begin
                    pitch_next = pitch_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : r_eff + ROW_W'(1);
            end
            else
            begin
                col_next = c_eff + CW'(1);
                row_next = r_eff;
            end
        end
    end

    assign line    = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign win_new = {line, s1_cur_reg};

    assign rd_en   = accept;
    assign rd_addr = c_eff;
    assign wr_en   = s1_adv;
    assign wr_addr = s1_col_reg;
    assign wr_data = {line[CELL_W-1:0], s1_cur_reg};

    // With a one-column frame the next pixel reads the entry written this cycle.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        fwd_hit_next  = fwd_hit_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            fwd_hit_next  = s1_adv && (s1_col_reg == c_eff);
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
            fwd_hit_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= CW'(RST_LAST_COL);
            last_row_reg <= ROW_W'(FRAME_H_RST - 1);
            pitch_reg    <= PITCH_RST;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            win0_reg     <= '0;
            win1_reg     <= '0;
            win2_reg     <= '0;
        end
        else
        begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            pitch_reg    <= pitch_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            fwd_hit_reg  <= fwd_hit_next;
            if (s1_adv)
            begin
                win0_reg <= win_new;
                win1_reg <= win0_reg;
                win2_reg <= win1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg      <= c_eff;
            s1_row_reg      <= r_eff;
            s1_row_end_reg  <= row_end;
            s1_last_row_reg <= last_row;
            s1_cur_reg      <= cell_of(pix.coverage);
            fwd_data_reg    <= wr_data;
        end
    end

    // Row-above texels use the three rows where they exist; last-row ones have none below.
    assign c_ge1    = (s1_col_reg != '0);
    assign c_ge2    = (s1_col_reg > CW'(1));
    assign r_ge1    = (s1_row_reg != '0);
    assign up_mask  = ((s1_row_reg > ROW_W'(1)) ? ROW_TOP_MASK : '0) | ROW_MID_MASK
                      | ROW_CUR_MASK;
    assign low_mask = (r_ge1 ? ROW_MID_MASK : '0) | ROW_CUR_MASK;

    always_comb
    begin
        bndl.pend[RES_UP_MID]  = r_ge1 && c_ge1;
        bndl.pend[RES_UP_END]  = r_ge1 && s1_row_end_reg;
        bndl.pend[RES_LOW_MID] = s1_last_row_reg && c_ge1;
        bndl.pend[RES_LOW_END] = s1_last_row_reg && s1_row_end_reg;
        bndl.texel[RES_UP_MID]  = make_texel(win1_reg, c_ge2, win0_reg, win_new, 1'b1,
                                             up_mask, 1'b1);
        bndl.texel[RES_UP_END]  = make_texel(win0_reg, c_ge1, win_new, '0, 1'b0,
                                             up_mask, 1'b1);
        bndl.texel[RES_LOW_MID] = make_texel(win1_reg, c_ge2, win0_reg, win_new, 1'b1,
                                             low_mask, 1'b0);
        bndl.texel[RES_LOW_END] = make_texel(win0_reg, c_ge1, win_new, '0, 1'b0,
                                             low_mask, 1'b0);
    end

    assign bndl_valid = s1_valid_reg;
    assign bndl_col   = s1_col_reg;
    assign bndl_row   = s1_row_reg;
    assign pitch      = pitch_reg;

    `GDIL_ASSERT_NEXT(a_col_in_frame, accept && !cfg_we, col_reg <= last_col_reg,
        "column counter left the frame")
    `GDIL_ASSERT_NEXT(a_row_in_frame, accept && !cfg_we, row_reg <= last_row_reg,
        "row counter left the frame")
    `GDIL_ASSERT(a_fwd_live, fwd_hit_reg |-> s1_valid_reg,
        "forwarded line data held with no pixel in the window stage")

endmodule

`default_nettype wire

// ===== rtl/gdil_emit.sv =====
// Output serializer: drains up to four texels per pixel, adds the byte offset,
// and holds them in the output register. Depends on gdil_pkg, gdil_if, assert macros.
`default_nettype none
`include "glyph_outline_dilate_3x3_assert.svh"

module gdil_emit import gdil_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = $clog2(MAX_WIDTH)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bundle_t            bndl,
    input  wire logic               bndl_valid,
    output logic                    bndl_ready,
    input  wire logic [CW-1:0]      bndl_col,
    input  wire logic [ROW_W-1:0]   bndl_row,
    input  wire logic [PITCH_W-1:0] pitch,
    gdil_out_if.source              tex
);

    logic [NUM_RES-1:0]              pend_reg, pend_next;
    logic [NUM_RES-1:0][TEXEL_W-1:0] texel_reg;
    logic [CW-1:0]                   col_reg;
    logic [ROW_W-1:0]                row_reg;
    logic                            ov_reg;
    logic [TEXEL_W-1:0]              o_texel_reg;
    logic [CW-1:0]                   o_col_reg;
    logic [ROW_W-1:0]                o_row_reg;
    logic [OFFS_W-1:0]               o_offs_reg;
    logic                            o_done_reg;

    logic                            out_load_ok;
    logic                            emit;
    logic                            load;
    logic [1:0]                      idx;
    logic [NUM_RES-1:0]              pend_after;
    logic [CW-1:0]                   sel_col;
    logic [ROW_W-1:0]                sel_row;
    logic [OFFS_W-1:0]               sel_offs;

    assign out_load_ok = !ov_reg || tex.ready;

    // Lowest pending slot goes first.
    always_comb
    begin
        idx = '0;
        for (int i = NUM_RES - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
                idx = 2'(i);
        end
    end

    assign emit       = (pend_reg != '0) && out_load_ok;
    assign pend_after = emit ? (pend_reg & ~(NUM_RES'(1) << idx)) : pend_reg;
    assign bndl_ready = (pend_after == '0);
    assign load       = bndl_valid && bndl_ready;
    assign pend_next  = load ? bndl.pend : pend_after;

    // Mid-row slots describe the pixel left of the current column; upper slots the row above.
    assign sel_col  = (idx == RES_UP_END || idx == RES_LOW_END) ? col_reg : col_reg - CW'(1);
    assign sel_row  = (idx == RES_LOW_MID || idx == RES_LOW_END) ? row_reg
                                                                  : row_reg - ROW_W'(1);
    assign sel_offs = OFFS_W'(sel_row) * OFFS_W'(pitch) + OFFS_W'({sel_col, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (out_load_ok)
                ov_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            texel_reg <= bndl.texel;
            col_reg   <= bndl_col;
            row_reg   <= bndl_row;
        end
        if (emit)
        begin
            o_texel_reg <= texel_reg[idx];
            o_col_reg   <= sel_col;
            o_row_reg   <= sel_row;
            o_offs_reg  <= sel_offs;
            o_done_reg  <= (idx == RES_LOW_END);
        end
    end

    assign tex.valid       = ov_reg;
    assign tex.texel       = o_texel_reg;
    assign tex.out_col     = OUT_COL_W'(o_col_reg);
    assign tex.out_row     = o_row_reg;
    assign tex.dest_offset = o_offs_reg;
    assign tex.frame_done  = o_done_reg;

    `GDIL_ASSERT(a_reload_drained,
        load |-> (pend_reg == '0 || ($onehot(pend_reg) && emit)),
        "texel bundle replaced while texels were still pending")
    `GDIL_ASSERT_NEXT(a_pend_shrinks, !load,
        $countones(pend_reg) <= $countones($past(pend_reg)),
        "pending texel count grew without a bundle load")

endmodule

`default_nettype wire

// ===== rtl/glyph_outline_dilate_3x3.sv =====
// Top level of the glyph outline dilation block: 3x3 dilated alpha, ARGB4444 texels.
// Instantiates gdil_window, gdil_linebuf and gdil_emit; depends on gdil_pkg and gdil_if.
`default_nettype none

// Coverage bytes enter on pix in raster order; each pixel yields the texel of the
// pixel above and to its left once its whole 3x3 neighborhood is known, so output
// runs one row behind, and the last row is emitted as it streams in. The single
// output register passes one texel per clock while tex is ready; a pixel that yields
// several holds the input until they drain. In frames wider than one column, on a
// row that is not the last each pixel yields at most one texel and the block takes
// one pixel per clock while the output keeps up, except the pixel that closes a row
// after the first, which yields two; on the last row each pixel after the first
// yields two texels and the one closing the row four, or one and two if the frame
// is a single row. A pixel passes the window stage, pending texel and output
// registers before its first texel appears. The MAX_WIDTH-entry line buffer is one
// memory with one read and one write per pixel; it needs no clearing after reset.
// The user writes registers on cfg between frames; the block does not enforce it.
module glyph_outline_dilate_3x3 import gdil_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    gdil_in_if.sink   pix,
    gdil_cfg_if.sink  cfg,
    gdil_out_if.source tex
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic               rd_en;
    logic [CW-1:0]      rd_addr;
    logic [LINE_W-1:0]  rd_data;
    logic               wr_en;
    logic [CW-1:0]      wr_addr;
    logic [LINE_W-1:0]  wr_data;
    bundle_t            bndl;
    logic               bndl_valid;
    logic               bndl_ready;
    logic [CW-1:0]      bndl_col;
    logic [ROW_W-1:0]   bndl_row;
    logic [PITCH_W-1:0] pitch;

    gdil_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .cfg        (cfg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .bndl       (bndl),
        .bndl_valid (bndl_valid),
        .bndl_ready (bndl_ready),
        .bndl_col   (bndl_col),
        .bndl_row   (bndl_row),
        .pitch      (pitch)
    );

    gdil_linebuf #(
        .DEPTH (MAX_WIDTH)
    ) u_linebuf (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    gdil_emit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .bndl       (bndl),
        .bndl_valid (bndl_valid),
        .bndl_ready (bndl_ready),
        .bndl_col   (bndl_col),
        .bndl_row   (bndl_row),
        .pitch      (pitch),
        .tex        (tex)
    );

endmodule

`default_nettype wire

// ===== tb/sv/gdil_texel_check.sv =====
`timescale 1ns / 100ps
// Texel predictor and comparator for the glyph outline dilation block. It
// watches the pixel, register and texel channels. Depends on gdil_pkg and gdil_if.
module gdil_texel_check import gdil_pkg::*;
#(
    parameter int LINE_DEPTH = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    gdil_in_if          pix,
    gdil_cfg_if         cfg,
    gdil_out_if         tex,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned texels_checked
);

    typedef struct {
        logic [TEXEL_W-1:0]   texel;
        logic [OUT_COL_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic [OFFS_W-1:0]    offset;
        logic                 done;
    } texel_t;

    texel_t expected_texels[$];

    // Each cell is {nonzero flag, grey nibble}.
    logic [CELL_W-1:0] cells_two_up[LINE_DEPTH];
    logic [CELL_W-1:0] cells_one_up[LINE_DEPTH];

    // Window columns hold {two rows up, one row up, current row}; col_new is the newest.
    logic [WIN_W-1:0] col_old, col_mid, col_new;

    logic [FRAME_FIELD_W-1:0] width_setting, height_setting;
    logic [PITCH_W-1:0]       pitch_setting;
    int unsigned              next_col, next_row;
    int unsigned              errors, checked;

    function automatic texel_t texel_for(
        input logic [WIN_W-1:0] left,
        input bit               has_left,
        input logic [WIN_W-1:0] center,
        input logic [WIN_W-1:0] right,
        input bit               has_right,
        input logic [WIN_W-1:0] rows_in_frame,
        input bit               upper_row,
        input int unsigned      col,
        input int unsigned      row,
        input bit               last
    );
        texel_t           t;
        logic [WIN_W-1:0] seen;
        logic [3:0]       grey;
        logic [3:0]       alpha;
        seen = center;
        if (has_left)
            seen = seen | left;
        if (has_right)
            seen = seen | right;
        seen  = seen & rows_in_frame & FLAG_MASK;
        alpha = (seen != '0) ? ALPHA_ON : 4'h0;
        grey  = upper_row ? center[CELL_W+3:CELL_W] : center[3:0];
        t.texel  = {alpha, grey, grey, grey};
        t.col    = OUT_COL_W'(col);
        t.row    = ROW_W'(row);
        t.offset = OFFS_W'(longint'(row) * longint'(pitch_setting) + 2 * longint'(col));
        t.done   = last;
        return t;
    endfunction

    task automatic take_pixel(input logic [COV_W-1:0] cov);
        int unsigned       w, h, c, r;
        bit                row_end, last_row;
        logic [CELL_W-1:0] pix_cell;
        logic [WIN_W-1:0]  upper_rows, lower_rows;
        w = width_setting;
        if (w == 0)
            w = 1;
        if (w > LINE_DEPTH)
            w = LINE_DEPTH;
        h = height_setting;
        if (h == 0)
            h = 1;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        // Counters left beyond a reduced size land on the row end or the last row.
        c = (next_col >= w) ? w - 1 : next_col;
        r = (next_row >= h) ? h - 1 : next_row;
        row_end  = (c == w - 1);
        last_row = (r == h - 1);

        // floor(v/17) is 15*v/255 truncated, without rounding trouble.
        pix_cell = {cov != '0, 4'(cov / 17)};
        col_old = col_mid;
        col_mid = col_new;
        col_new = {cells_two_up[c], cells_one_up[c], pix_cell};
        cells_two_up[c] = cells_one_up[c];
        cells_one_up[c] = pix_cell;

        upper_rows = ROW_MID_MASK | ROW_CUR_MASK;
        if (r >= 2)
            upper_rows = upper_rows | ROW_TOP_MASK;
        lower_rows = ROW_CUR_MASK;
        if (r >= 1)
            lower_rows = lower_rows | ROW_MID_MASK;

        // The row above is finished one pixel late; the last row goes out as it arrives.
        if (r >= 1)
        begin
            if (c >= 1)
                expected_texels.push_back(texel_for(col_old, c >= 2, col_mid, col_new, 1'b1,
                                                    upper_rows, 1'b1, c - 1, r - 1, 1'b0));
            if (row_end)
                expected_texels.push_back(texel_for(col_mid, c >= 1, col_new, '0, 1'b0,
                                                    upper_rows, 1'b1, c, r - 1, 1'b0));
        end
        if (last_row)
        begin
            if (c >= 1)
                expected_texels.push_back(texel_for(col_old, c >= 2, col_mid, col_new, 1'b1,
                                                    lower_rows, 1'b0, c - 1, r, 1'b0));
            if (row_end)
                expected_texels.push_back(texel_for(col_mid, c >= 1, col_new, '0, 1'b0,
                                                    lower_rows, 1'b0, c, r, 1'b1));
        end

        if (row_end)
        begin
            next_col = 0;
            next_row = last_row ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
            next_row = r;
        end
    endtask

    task automatic check_texel();
        texel_t want;
        if (expected_texels.size() == 0)
        begin
            $error("texel at col %0d row %0d arrived with none expected",
                   tex.out_col, tex.out_row);
            errors++;
        end
        else
        begin
            want = expected_texels.pop_front();
            checked++;
            if (tex.texel !== want.texel)
            begin
                $error("texel: expected %h, actual %h", want.texel, tex.texel);
                errors++;
            end
            if (tex.out_col !== want.col)
            begin
                $error("out_col: expected %0d, actual %0d", want.col, tex.out_col);
                errors++;
            end
            if (tex.out_row !== want.row)
            begin
                $error("out_row: expected %0d, actual %0d", want.row, tex.out_row);
                errors++;
            end
            if (tex.dest_offset !== want.offset)
            begin
                $error("dest_offset: expected %0d, actual %0d", want.offset, tex.dest_offset);
                errors++;
            end
            if (tex.frame_done !== want.done)
            begin
                $error("frame_done: expected %b, actual %b", want.done, tex.frame_done);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_setting  = FRAME_FIELD_W'(FRAME_W_RST);
            height_setting = FRAME_FIELD_W'(FRAME_H_RST);
            pitch_setting  = PITCH_RST;
            col_old  = '0;
            col_mid  = '0;
            col_new  = '0;
            next_col = 0;
            next_row = 0;
            errors   = 0;
            checked  = 0;
            for (int i = 0; i < LINE_DEPTH; i++)
            begin
                cells_two_up[i] = '0;
                cells_one_up[i] = '0;
            end
            expected_texels.delete();
            fail_count     <= 0;
            pending        <= 0;
            texels_checked <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_FRAME_WIDTH:  width_setting  = cfg.data[FRAME_FIELD_W-1:0];
                    CFG_FRAME_HEIGHT: height_setting = cfg.data[FRAME_FIELD_W-1:0];
                    CFG_DEST_PITCH:   pitch_setting  = cfg.data[PITCH_W-1:0];
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready)
                take_pixel(pix.coverage);
            if (tex.valid && tex.ready)
                check_texel();
            fail_count     <= errors;
            pending        <= expected_texels.size();
            texels_checked <= checked;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for glyph_outline_dilate_3x3: drives pixels and register writes,
// stalls the texel output and gives the verdict. Depends on gdil_pkg, gdil_if, gdil_texel_check.
module tb_top;
    import gdil_pkg::*;

    // Index with no register behind it; the block drops writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int SIZE_MAX      = 2048;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 250;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PIXELS = 230;
    localparam int WIDE_PIXELS   = 20;
    localparam int TALL_PIXELS   = 30;

    logic clk;
    logic rst_n;

    gdil_in_if  pix();
    gdil_cfg_if cfg();
    gdil_out_if tex();

    int unsigned fail_count, pending, texels_checked;
    int unsigned pixels_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned reg_writes  = 0;
    int unsigned idle_cycles = 0;
    int unsigned hold_asked;
    bit          no_idle;

    logic [FRAME_FIELD_W-1:0] width_now, height_now;

    logic [COV_W-1:0] first_frame[12] = '{8'd0, 8'd255, 8'd16, 8'd17,
                                          8'd0, 8'd0, 8'd33, 8'd34,
                                          8'd1, 8'd0, 8'd0, 8'd254};

    glyph_outline_dilate_3x3 i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .cfg   (cfg),
        .tex   (tex)
    );

    gdil_texel_check i_texel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix            (pix),
        .cfg            (cfg),
        .tex            (tex),
        .fail_count     (fail_count),
        .pending        (pending),
        .texels_checked (texels_checked)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COV_W-1:0] random_coverage(input int unsigned density);
        if ($urandom_range(0, 99) >= density)
            return '0;
        return COV_W'($urandom_range(1, 255));
    endfunction

    function automatic int unsigned clamp_size(input logic [FRAME_FIELD_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > SIZE_MAX)
            return SIZE_MAX;
        return 32'(d);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] size_word(input int unsigned size);
        // The bits above the size field carry noise; the block ignores them.
        return {4'($urandom), FRAME_FIELD_W'(size)};
    endfunction

    task automatic send_pixel(input logic [COV_W-1:0] value);
        int unsigned gap;
        pix.valid    <= 1'b1;
        pix.coverage <= value;
        do @(posedge clk); while (!pix.ready);
        pixels_sent++;
        gap = pick_gap(no_idle);
        if (gap != 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_pixels(input int unsigned count, input int unsigned density);
        repeat (count) send_pixel(random_coverage(density));
    endtask

    // Waits until every predicted texel has arrived and the pipeline has emptied.
    task automatic settle();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
        case (index)
            CFG_FRAME_WIDTH:  width_now  = data[FRAME_FIELD_W-1:0];
            CFG_FRAME_HEIGHT: height_now = data[FRAME_FIELD_W-1:0];
            default: ;
        endcase
    endtask

    // Output side: random stalls, plus one long hold on request.
    initial
    begin
        int unsigned stall;
        int unsigned hold_served;
        hold_served = 0;
        tex.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever
        begin
            if (hold_asked != hold_served)
            begin
                hold_served = hold_asked;
                tex.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                stall = pick_gap(no_idle);
                tex.ready <= (stall == 0);
                repeat ((stall == 0) ? 1 : stall) @(posedge clk);
            end
        end
    end

    // A cycle with no transfer on any channel counts toward the timeout.
    always @(posedge clk)
    begin
        if (!rst_n || (pix.valid && pix.ready) || (tex.valid && tex.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned w, h, density, frame_idx, random_start;
        rst_n        <= 1'b0;
        pix.valid    <= 1'b0;
        pix.coverage <= '0;
        cfg.valid    <= 1'b0;
        cfg.index    <= CFG_FRAME_WIDTH;
        cfg.data     <= '0;
        no_idle      <= 1'b0;
        hold_asked   <= 0;
        width_now    = FRAME_FIELD_W'(FRAME_W_RST);
        height_now   = FRAME_FIELD_W'(FRAME_H_RST);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Small frame with the pitch still at its reset value; values near
        // multiples of 17 probe the grey division.
        write_reg(CFG_FRAME_WIDTH, 16'd4);
        write_reg(CFG_FRAME_HEIGHT, 16'd3);
        foreach (first_frame[i])
            send_pixel(first_frame[i]);
        frames_sent++;
        settle();

        // Zero sizes act as one pixel; a pitch below two is used as given.
        write_reg(CFG_FRAME_WIDTH, 16'd0);
        write_reg(CFG_FRAME_HEIGHT, 16'd0);
        write_reg(CFG_DEST_PITCH, 16'd1);
        write_reg(CFG_SPARE, 16'hFFFF);
        send_pixel(8'd200);
        frames_sent++;
        settle();

        // High bits of the size words must be ignored; one isolated pixel on the last row.
        write_reg(CFG_FRAME_WIDTH, 16'hF003);
        write_reg(CFG_FRAME_HEIGHT, 16'hA002);
        write_reg(CFG_DEST_PITCH, 16'd0);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd128);
        send_pixel(8'd0);
        frames_sent++;
        settle();

        // Oversized width saturates and the largest pitch gives the largest offsets.
        // Part of the wide first row goes in, then the width drops below the column
        // reached, so the next pixel closes that row.
        write_reg(CFG_FRAME_WIDTH, 16'h0FFF);
        write_reg(CFG_FRAME_HEIGHT, 16'd2);
        write_reg(CFG_DEST_PITCH, 16'hFFFF);
        send_pixels(WIDE_PIXELS, 20);
        settle();
        write_reg(CFG_FRAME_WIDTH, 16'd4);
        send_pixels(1 + 4, 20);
        frames_sent++;
        settle();

        // Oversized height saturates; the height then drops below the row reached.
        write_reg(CFG_FRAME_WIDTH, 16'd1);
        write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
        send_pixels(TALL_PIXELS, 30);
        settle();
        write_reg(CFG_FRAME_HEIGHT, 16'd3);
        send_pixels(1, 30);
        frames_sent++;
        settle();

        random_start = pixels_sent;
        frame_idx    = 0;
        // The loop always reaches the frames with the long hold and the resizes.
        while (pixels_sent - random_start < RANDOM_PIXELS || frame_idx <= 6)
        begin
            no_idle <= ($urandom_range(0, 3) == 0);
            density = $urandom_range(5, 100);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            if (frame_idx == 2)
            begin
                w = 12;
                h = 5;
            end
            else if (frame_idx == 4)
            begin
                w = $urandom_range(3, 8);
                h = 6;
            end
            else if (frame_idx == 6)
            begin
                w = $urandom_range(5, 9);
                h = 4;
            end
            write_reg(CFG_FRAME_WIDTH, size_word(w));
            write_reg(CFG_FRAME_HEIGHT, size_word(h));
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_DEST_PITCH, CFG_DATA_W'($urandom_range(0, 65535)));
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom));

            if (frame_idx == 2)
            begin
                // The output holds off while the input keeps coming, so the block backs up.
                no_idle    <= 1'b1;
                hold_asked <= hold_asked + 1;
                send_pixels(w * h, density);
            end
            else if (frame_idx == 4)
            begin
                // Height drops below the current row: the rest of that row becomes the last row.
                send_pixels(2 * w + 2, density);
                settle();
                write_reg(CFG_FRAME_HEIGHT, size_word(2));
                send_pixels(w - 2, density);
            end
            else if (frame_idx == 6)
            begin
                // Width drops below the current column on row one: that pixel ends the row.
                send_pixels(w + 4, density);
                settle();
                write_reg(CFG_DEST_PITCH, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(CFG_FRAME_WIDTH, size_word(3));
                send_pixels(1 + 2 * 3, density);
            end
            else
                send_pixels(clamp_size(width_now) * clamp_size(height_now), density);
            frames_sent++;
            frame_idx++;
            settle();
        end

        $display("summary: %0d pixels in %0d frames, %0d texels compared, %0d register writes",
                 pixels_sent, frames_sent, texels_checked, reg_writes);
        $display("summary: sizes from 1x1 up to saturated 2048 settings, four mid-frame %s",
                 "resizes and one long output hold");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gdil_pkg.sv
rtl/gdil_if.sv
rtl/gdil_linebuf.sv
rtl/gdil_window.sv
rtl/gdil_emit.sv
rtl/glyph_outline_dilate_3x3.sv
tb/sv/gdil_texel_check.sv
tb/sv/tb_top.sv
